FILE: hdl/ultrasonic_echo_ranger_smoothed_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the echo ranger
// Shared property wrappers, clocked on clk and disabled during rst_n low.
// ---------------------------------------------------------------------------
`ifndef ULTRASONIC_ECHO_RANGER_SMOOTHED_ASSERT_SVH
`define ULTRASONIC_ECHO_RANGER_SMOOTHED_ASSERT_SVH

// Same-cycle implication
`define UER_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define UER_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/uer_pkg.sv
// ---------------------------------------------------------------------------
// uer_pkg
// Widths, timing constants, divider reciprocals and types of the echo ranger.
// ---------------------------------------------------------------------------
package uer_pkg;

  // Moving-average depth and ring index width
  localparam int AVG_DEPTH  = 10;
  localparam int HIST_IDX_W = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
  localparam logic [HIST_IDX_W-1:0] HIST_LAST = HIST_IDX_W'(AVG_DEPTH - 1);

  // Field widths
  localparam int US_W    = 20;
  localparam int TOTAL_W = 24;
  localparam int CM_W    = 23;
  localparam int INCH_W  = 21;
  localparam int TICK_W  = 4;
  localparam int PHASE_W = 3;
  localparam int IN_W    = 8;
  localparam int OUT_W   = 88;

  // Trigger pulse timing in ticks
  localparam logic [TICK_W-1:0] LOW_TICKS  = TICK_W'(2);
  localparam logic [TICK_W-1:0] HIGH_TICKS = TICK_W'(10);

  localparam logic [US_W-1:0] TIMEOUT_RST = US_W'(1000000);

  // Exact reciprocal multipliers: floor(x / D) == (x * MUL) >> SH over the
  // whole operand range, with MUL = ceil(2^SH / D)
  localparam int MUL_W     = 30;
  localparam int AVG_SH    = 29;
  localparam logic [MUL_W-1:0] AVG_MUL =
    MUL_W'(((64'd1 << AVG_SH) + 64'(AVG_DEPTH) - 64'd1) / 64'(AVG_DEPTH));

  localparam int FRAC_W    = 8;
  localparam int NUM_W     = US_W + FRAC_W + 1;
  localparam int CM_DIV    = 58;
  localparam int CM_SH     = 35;
  localparam logic [MUL_W-1:0] CM_MUL =
    MUL_W'(((64'd1 << CM_SH) + 64'(CM_DIV) - 64'd1) / 64'(CM_DIV));
  localparam int INCH_DIV  = 148;
  localparam int INCH_SH   = 37;
  localparam logic [MUL_W-1:0] INCH_MUL =
    MUL_W'(((64'd1 << INCH_SH) + 64'(INCH_DIV) - 64'd1) / 64'(INCH_DIV));

  // Flags of one result
  typedef struct packed {
    logic trig;
    logic busy;
    logic done;
    logic timed;
  } res_flags_t;

  // Snapshot taken when a tick is accepted
  typedef struct packed {
    res_flags_t          flags;
    logic [US_W-1:0]     raw;
    logic [TOTAL_W-1:0]  total;
  } tick_snap_t;

endpackage

FILE: hdl/ultrasonic_echo_ranger_smoothed.sv
// ---------------------------------------------------------------------------
// ultrasonic_echo_ranger_smoothed
// Trigger/echo sequencer for an ultrasonic ranger with a moving-average
// smoother and fixed-point distance conversion.
// ---------------------------------------------------------------------------
//  channel  | direction | handshake             | payload
//  ---------+-----------+-----------------------+-------------------------------
//  in_      | slave     | in_tvalid/in_tready   | start_req, echo_level
//  out_     | master    | out_tvalid/out_tready | flags, widths, distances (Q8)
//  cfg_     | slave     | cfg_valid/cfg_ready   | timeout_us (20 bits)
//
//  A tick is accepted whenever in_tready is high; its result reaches out_tdata
//  via the snapshot, average/inch multiply and centimetre multiply registers.
//  Unstalled throughput: one tick per cycle, set by the three-stage pipeline.
//  Synchronous active-low reset clears the sequencer, the 10-entry history
//  ring, the running total and the pipeline valids; timeout returns to 1e6.
//  A stall on out_tready holds full stages; in_tready drops once all three fill.
// ---------------------------------------------------------------------------
`include "ultrasonic_echo_ranger_smoothed_assert.svh"

module ultrasonic_echo_ranger_smoothed (
  input  logic                        clk,
  input  logic                        rst_n,
  // tick input: [0] start_req, [1] echo_level, [7:2] zero
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [uer_pkg::IN_W-1:0]    in_tdata,
  // result: [0] trigger_out, [1] busy_res, [2] done_res, [3] timed_out,
  //         [23:4] raw_width_us, [43:24] average_us,
  //         [66:44] distance_cm_q8, [87:67] distance_inch_q8
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [uer_pkg::OUT_W-1:0]   out_tdata,
  // timeout register write
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [uer_pkg::US_W-1:0]    cfg_data
);
  import uer_pkg::*;

  // Sequencer phase codes
  localparam logic [PHASE_W-1:0] PH_IDLE      = 3'd0;
  localparam logic [PHASE_W-1:0] PH_TRIG_LOW  = 3'd1;
  localparam logic [PHASE_W-1:0] PH_TRIG_HIGH = 3'd2;
  localparam logic [PHASE_W-1:0] PH_WAIT_LOW  = 3'd3;
  localparam logic [PHASE_W-1:0] PH_WAIT_HIGH = 3'd4;
  localparam logic [PHASE_W-1:0] PH_MEASURE   = 3'd5;

  // Sequencer and history state
  logic [US_W-1:0]        timeout_r;
  logic [PHASE_W-1:0]     phase_r, phase_nxt, phase_go;
  logic [TICK_W-1:0]      phase_ticks_r, phase_ticks_nxt;
  logic [US_W-1:0]        elapsed_r, elapsed_nxt;
  logic [US_W-1:0]        echo_width_r, echo_width_nxt;
  logic [US_W-1:0]        hist_r [AVG_DEPTH];
  logic [HIST_IDX_W-1:0]  hist_idx_r, hist_idx_nxt, hist_idx;
  logic [TOTAL_W-1:0]     total_r, total_nxt;
  logic [US_W-1:0]        result_hold_r, result_hold_nxt;
  logic                   timed_r, timed_nxt;

  logic                   start_req, echo_level;
  logic                   trig, fin, fin_to;
  logic [US_W-1:0]        fin_w;
  logic                   in_acc;

  // Pipeline registers
  logic                   v1_r, v2_r, out_v_r;
  tick_snap_t             s1_r, s1_nxt;
  res_flags_t             flags2_r, flags_o_r;
  logic [US_W-1:0]        raw2_r, raw_o_r;
  logic [US_W-1:0]        avg2_r, avg_o_r;
  logic [INCH_W-1:0]      inch2_r, inch_o_r;
  logic [CM_W-1:0]        cm_o_r;
  logic                   adv_o, adv2, adv1;

  logic [TOTAL_W+MUL_W-1:0] avg_prod;
  logic [NUM_W+MUL_W-1:0]   inch_prod, cm_prod;
  logic [NUM_W-1:0]         inch_num, cm_num;

  assign start_req = in_tdata[0];
  assign echo_level = in_tdata[1];

  // Stage advance: each stage moves when the one after it has room
  assign adv_o     = !out_v_r || out_tready;
  assign adv2      = !v2_r || adv_o;
  assign adv1      = !v1_r || adv2;
  assign in_tready = adv1;
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // Ring slot for this tick, wrapped into range
  assign hist_idx = (hist_idx_r > HIST_LAST) ? '0 : hist_idx_r;

  // Sequencer next state for one tick
  always_comb begin
    phase_go        = phase_r;
    phase_ticks_nxt = phase_ticks_r;
    elapsed_nxt     = elapsed_r;
    echo_width_nxt  = echo_width_r;
    trig            = 1'b0;
    fin             = 1'b0;
    fin_to          = 1'b0;
    fin_w           = '0;
    if (phase_r == PH_IDLE && start_req) begin
      phase_go        = PH_TRIG_LOW;
      phase_ticks_nxt = '0;
      elapsed_nxt     = '0;
      echo_width_nxt  = '0;
    end
    phase_nxt = phase_go;
    if (phase_go != PH_IDLE) begin
      if (elapsed_nxt != '1) begin
        elapsed_nxt = elapsed_nxt + US_W'(1);
      end
      unique case (phase_go)
        PH_TRIG_LOW: begin
          phase_ticks_nxt = phase_ticks_nxt + TICK_W'(1);
          if (phase_ticks_nxt >= LOW_TICKS) begin
            phase_nxt       = PH_TRIG_HIGH;
            phase_ticks_nxt = '0;
          end
        end
        PH_TRIG_HIGH: begin
          trig            = 1'b1;
          phase_ticks_nxt = phase_ticks_nxt + TICK_W'(1);
          if (phase_ticks_nxt >= HIGH_TICKS) begin
            phase_nxt       = PH_WAIT_LOW;
            phase_ticks_nxt = '0;
          end
        end
        PH_WAIT_LOW: begin
          if (!echo_level) begin
            phase_nxt = PH_WAIT_HIGH;
          end
        end
        PH_WAIT_HIGH: begin
          if (echo_level) begin
            phase_nxt      = PH_MEASURE;
            echo_width_nxt = US_W'(1);
          end
        end
        default: begin
          // measure: count high ticks, finish on the first low one
          if (echo_level) begin
            echo_width_nxt = echo_width_nxt + US_W'(1);
          end else begin
            fin   = 1'b1;
            fin_w = echo_width_nxt;
          end
        end
      endcase
      // Give up once the elapsed count reaches the timeout
      if (!fin && (phase_nxt == PH_WAIT_LOW || phase_nxt == PH_WAIT_HIGH ||
                   phase_nxt == PH_MEASURE) && elapsed_nxt >= timeout_r) begin
        fin    = 1'b1;
        fin_to = 1'b1;
        fin_w  = '0;
      end
    end
    if (fin) begin
      phase_nxt       = PH_IDLE;
      phase_ticks_nxt = '0;
    end
  end

  // History ring update on a finished measurement
  always_comb begin
    total_nxt       = total_r;
    hist_idx_nxt    = hist_idx_r;
    result_hold_nxt = result_hold_r;
    timed_nxt       = timed_r;
    if (fin) begin
      total_nxt       = total_r - TOTAL_W'(hist_r[hist_idx]) + TOTAL_W'(fin_w);
      hist_idx_nxt    = (hist_idx == HIST_LAST) ? '0 : hist_idx + HIST_IDX_W'(1);
      result_hold_nxt = fin_w;
      timed_nxt       = fin_to;
    end
  end

  // Snapshot of what the result needs from this tick
  always_comb begin
    s1_nxt.flags.trig  = trig;
    s1_nxt.flags.busy  = (phase_nxt != PH_IDLE);
    s1_nxt.flags.done  = fin;
    s1_nxt.flags.timed = timed_nxt;
    s1_nxt.raw         = result_hold_nxt;
    s1_nxt.total       = total_nxt;
  end

  // Hold configuration and sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r     <= TIMEOUT_RST;
      phase_r       <= PH_IDLE;
      phase_ticks_r <= '0;
      elapsed_r     <= '0;
      echo_width_r  <= '0;
      hist_idx_r    <= '0;
      total_r       <= '0;
      result_hold_r <= '0;
      timed_r       <= 1'b0;
      for (int i = 0; i < AVG_DEPTH; i++) begin
        hist_r[i] <= '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        timeout_r <= cfg_data;
      end
      if (in_acc) begin
        phase_r       <= phase_nxt;
        phase_ticks_r <= phase_ticks_nxt;
        elapsed_r     <= elapsed_nxt;
        echo_width_r  <= echo_width_nxt;
        hist_idx_r    <= hist_idx_nxt;
        total_r       <= total_nxt;
        result_hold_r <= result_hold_nxt;
        timed_r       <= timed_nxt;
        if (fin) begin
          hist_r[hist_idx] <= fin_w;
        end
      end
    end
  end

  // Average and inch conversion by reciprocal multiply
  assign avg_prod  = (TOTAL_W+MUL_W)'(s1_r.total) * (TOTAL_W+MUL_W)'(AVG_MUL);
  assign inch_num  = NUM_W'({s1_r.raw, FRAC_W'(0)}) + NUM_W'(INCH_DIV / 2);
  assign inch_prod = (NUM_W+MUL_W)'(inch_num) * (NUM_W+MUL_W)'(INCH_MUL);

  // Centimetre conversion of the registered average
  assign cm_num  = NUM_W'({avg2_r, FRAC_W'(0)}) + NUM_W'(CM_DIV / 2);
  assign cm_prod = (NUM_W+MUL_W)'(cm_num) * (NUM_W+MUL_W)'(CM_MUL);

  // Valid bits of the pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (adv1) begin
        v1_r <= in_tvalid;
      end
      if (adv2) begin
        v2_r <= v1_r;
      end
      if (adv_o) begin
        out_v_r <= v2_r;
      end
    end
  end

  // Advance pipeline payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_r <= s1_nxt;
    end
    if (adv2 && v1_r) begin
      flags2_r <= s1_r.flags;
      raw2_r   <= s1_r.raw;
      avg2_r   <= avg_prod[AVG_SH +: US_W];
      inch2_r  <= inch_prod[INCH_SH +: INCH_W];
    end
    if (adv_o && v2_r) begin
      flags_o_r <= flags2_r;
      raw_o_r   <= raw2_r;
      avg_o_r   <= avg2_r;
      inch_o_r  <= inch2_r;
      cm_o_r    <= cm_prod[CM_SH +: CM_W];
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {inch_o_r, cm_o_r, avg_o_r, raw_o_r,
                       flags_o_r.timed, flags_o_r.done,
                       flags_o_r.busy, flags_o_r.trig};

  // Checks
  `UER_ASSERT_IMPL(a_hist_idx_range, 1'b1, hist_idx_r <= HIST_LAST,
    "history index out of range")
  `UER_ASSERT_IMPL(a_trig_high_count, phase_r == PH_TRIG_HIGH,
    phase_ticks_r < HIGH_TICKS, "trigger high count overran")
  `UER_ASSERT_IMPL(a_timeout_zero, v1_r && s1_r.flags.done && s1_r.flags.timed,
    s1_r.raw == '0 && !s1_r.flags.busy, "timed-out result not zero width")
  `UER_ASSERT_NEXT(a_stage2_hold, v2_r && !adv_o,
    v2_r && $stable(avg2_r) && $stable(inch2_r), "stalled stage lost data")

endmodule

FILE: tb/ultrasonic_echo_ranger_smoothed_checker.sv
// ----------------------------------------------------------------------------
// Echo ranger result checker
// Watches the tick, result and timeout channels of the ranger. Keeps its own
// trigger/echo sequencer, history ring and distance arithmetic. Each accepted
// result transaction is compared field by field against the oldest
// prediction.
// ----------------------------------------------------------------------------
module echo_ranger_checker (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  input  logic                      in_tready,
  input  logic [uer_pkg::IN_W-1:0]  in_tdata,
  input  logic                      out_tvalid,
  input  logic                      out_tready,
  input  logic [uer_pkg::OUT_W-1:0] out_tdata,
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic [uer_pkg::US_W-1:0]  cfg_data,
  output int                        error_count,
  output int                        outstanding,
  output int                        tick_count,
  output int                        measure_count,
  output int                        timeout_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TRIG_LOW_TICKS  = 2;
  localparam int TRIG_HIGH_TICKS = 10;
  localparam int CM_DIVISOR      = 58;
  localparam int INCH_DIVISOR    = 148;

  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_TRIG_LOW,
    SEQ_TRIG_HIGH,
    SEQ_WAIT_LOW,
    SEQ_WAIT_HIGH,
    SEQ_MEASURE
  } seq_state_t;

  // Result layout, highest field first so it maps straight onto out_tdata
  typedef struct packed {
    logic [uer_pkg::INCH_W-1:0] inch;
    logic [uer_pkg::CM_W-1:0]   cm;
    logic [uer_pkg::US_W-1:0]   avg;
    logic [uer_pkg::US_W-1:0]   raw;
    logic                       timed;
    logic                       done;
    logic                       busy;
    logic                       trig;
  } ranger_result_t;

  // Sequencer and smoother state
  logic [uer_pkg::US_W-1:0]    timeout_val;
  seq_state_t                  seq;
  logic [3:0]                  seq_ticks;
  logic [uer_pkg::US_W-1:0]    elapsed;
  logic [uer_pkg::US_W-1:0]    width_cnt;
  logic [uer_pkg::US_W-1:0]    ring [uer_pkg::AVG_DEPTH];
  logic [3:0]                  ring_pos;
  logic [uer_pkg::TOTAL_W-1:0] total;
  logic [uer_pkg::US_W-1:0]    last_width;
  logic                        last_timed;

  ranger_result_t expected_results [$];
  int errors;
  int results_seen;
  int ticks_seen;
  int measures;
  int timeouts;

  function automatic void clear_model();
    int i;
    timeout_val = uer_pkg::TIMEOUT_RST;
    seq         = SEQ_IDLE;
    seq_ticks   = '0;
    elapsed     = '0;
    width_cnt   = '0;
    for (i = 0; i < uer_pkg::AVG_DEPTH; i++) ring[i] = '0;
    ring_pos    = '0;
    total       = '0;
    last_width  = '0;
    last_timed  = 1'b0;
    expected_results.delete();
  endfunction

  // Push a finished width into the ring and update the running total
  function automatic void commit_width(input logic [uer_pkg::US_W-1:0] w, input logic to);
    logic [3:0] idx;
    idx = (ring_pos >= uer_pkg::AVG_DEPTH) ? 4'd0 : ring_pos;
    total = total - uer_pkg::TOTAL_W'(ring[idx]) + uer_pkg::TOTAL_W'(w);
    ring[idx] = w;
    idx = idx + 4'd1;
    ring_pos = (idx >= uer_pkg::AVG_DEPTH) ? 4'd0 : idx;
    last_width = w;
    last_timed = to;
    seq = SEQ_IDLE;
    seq_ticks = '0;
  endfunction

  // Advance one microsecond tick and return what the block should report
  function automatic ranger_result_t step_ranger(input logic start, input logic echo);
    ranger_result_t r;
    logic trig;
    logic done;
    logic [uer_pkg::US_W-1:0] avg;
    logic [63:0] cm_q8;
    logic [63:0] inch_q8;
    trig = 1'b0;
    done = 1'b0;
    if (seq == SEQ_IDLE && start) begin
      seq = SEQ_TRIG_LOW;
      seq_ticks = '0;
      elapsed = '0;
      width_cnt = '0;
    end
    if (seq != SEQ_IDLE) begin
      if (elapsed != '1) elapsed = elapsed + 1'b1;
      case (seq)
        SEQ_TRIG_LOW: begin
          seq_ticks = seq_ticks + 4'd1;
          if (seq_ticks >= TRIG_LOW_TICKS) begin
            seq = SEQ_TRIG_HIGH;
            seq_ticks = '0;
          end
        end
        SEQ_TRIG_HIGH: begin
          trig = 1'b1;
          seq_ticks = seq_ticks + 4'd1;
          if (seq_ticks >= TRIG_HIGH_TICKS) begin
            seq = SEQ_WAIT_LOW;
            seq_ticks = '0;
          end
        end
        SEQ_WAIT_LOW: begin
          if (!echo) seq = SEQ_WAIT_HIGH;
        end
        SEQ_WAIT_HIGH: begin
          if (echo) begin
            seq = SEQ_MEASURE;
            width_cnt = uer_pkg::US_W'(1);
          end
        end
        default: begin
          if (echo) begin
            width_cnt = width_cnt + 1'b1;
          end else begin
            commit_width(width_cnt, 1'b0);
            done = 1'b1;
          end
        end
      endcase
      // Give up once the tick budget from start is used up
      if (!done && (seq == SEQ_WAIT_LOW || seq == SEQ_WAIT_HIGH || seq == SEQ_MEASURE) &&
          elapsed >= timeout_val) begin
        commit_width('0, 1'b1);
        done = 1'b1;
      end
    end
    avg = uer_pkg::US_W'(total / uer_pkg::TOTAL_W'(uer_pkg::AVG_DEPTH));
    cm_q8 = ((64'(avg) << 8) + 64'(CM_DIVISOR / 2)) / 64'(CM_DIVISOR);
    inch_q8 = ((64'(last_width) << 8) + 64'(INCH_DIVISOR / 2)) / 64'(INCH_DIVISOR);
    r.trig  = trig;
    r.busy  = (seq != SEQ_IDLE);
    r.done  = done;
    r.timed = last_timed;
    r.raw   = last_width;
    r.avg   = avg;
    r.cm    = uer_pkg::CM_W'(cm_q8);
    r.inch  = uer_pkg::INCH_W'(inch_q8);
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] seen);
    if (want !== seen) begin
      errors++;
      if (errors <= 10)
        $display("mismatch on result %0d, %s: expected %0d (0x%0h), got %0d (0x%0h)",
                 results_seen, name, want, want, seen, seen);
    end
  endfunction

  // Predict on accepted ticks, compare on accepted results
  always @(posedge clk) begin
    ranger_result_t want;
    ranger_result_t got;
    if (!rst_n) begin
      clear_model();
    end else begin
      if (cfg_valid && cfg_ready) timeout_val = cfg_data;
      if (in_tvalid && in_tready) begin
        want = step_ranger(in_tdata[0], in_tdata[1]);
        expected_results.push_back(want);
        ticks_seen++;
        if (want.done) measures++;
        if (want.done && want.timed) timeouts++;
      end
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (expected_results.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("result %0d arrived with nothing predicted: 0x%0h", results_seen,
                     out_tdata);
        end else begin
          want = expected_results.pop_front();
          check_field("trigger_out", 32'(want.trig), 32'(got.trig));
          check_field("busy_res", 32'(want.busy), 32'(got.busy));
          check_field("done_res", 32'(want.done), 32'(got.done));
          check_field("timed_out", 32'(want.timed), 32'(got.timed));
          check_field("raw_width_us", 32'(want.raw), 32'(got.raw));
          check_field("average_us", 32'(want.avg), 32'(got.avg));
          check_field("distance_cm_q8", 32'(want.cm), 32'(got.cm));
          check_field("distance_inch_q8", 32'(want.inch), 32'(got.inch));
        end
        results_seen++;
      end
    end
    error_count   <= errors;
    outstanding   <= expected_results.size();
    tick_count    <= ticks_seen;
    measure_count <= measures;
    timeout_count <= timeouts;
  end

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// Echo ranger testbench
// Drives microsecond ticks into the ranger as trigger/echo sequences with
// random echo timing, plus loose noise, across several timeout settings.
// Both channels idle in random bursts; a side checker predicts every result.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_tvalid = 1'b0;
  logic                      in_tready;
  logic [uer_pkg::IN_W-1:0]  in_tdata = '0;
  logic                      out_tvalid;
  logic                      out_tready = 1'b1;
  logic [uer_pkg::OUT_W-1:0] out_tdata;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [uer_pkg::US_W-1:0]  cfg_data = '0;

  logic quiet = 1'b0;
  int   stall_left = 0;
  int   ticks_sent = 0;
  int   settings_written = 0;

  int error_count;
  int outstanding;
  int tick_count;
  int measure_count;
  int timeout_count;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  ultrasonic_echo_ranger_smoothed u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  echo_ranger_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .error_count   (error_count),
    .outstanding   (outstanding),
    .tick_count    (tick_count),
    .measure_count (measure_count),
    .timeout_count (timeout_count)
  );

  // Stall the result side in random bursts
  always @(posedge clk) begin
    if (!rst_n || quiet) begin
      out_tready <= 1'b1;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 11) == 0) begin
      out_tready <= 1'b0;
      stall_left <= $urandom_range(0, 18);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Offer one tick transaction, with an occasional idle burst ahead of it
  task automatic send_tick(input logic start, input logic echo);
    if (!quiet && $urandom_range(0, 9) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'b0, echo, start};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    ticks_sent++;
  endtask

  // Drain all results, then write the timeout register
  task automatic write_timeout(input logic [uer_pkg::US_W-1:0] value);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    settings_written++;
  endtask

  // One well-formed measurement: start, trigger ticks, echo still high from
  // before, low gap, echo pulse, falling tick, then a few idle ticks
  task automatic run_echo(input int lead_high, input int low_gap, input int pulse,
                          input int tail);
    send_tick(1'b1, 1'($urandom_range(0, 1)));
    repeat (11) send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    repeat (lead_high) send_tick(1'b0, 1'b1);
    repeat (low_gap) send_tick(1'b0, 1'b0);
    repeat (pulse) send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b0);
    repeat (tail) send_tick(1'b0, 1'($urandom_range(0, 1)));
  endtask

  // Loose ticks: random echo, sparse start requests
  task automatic noise_ticks(input int count);
    repeat (count) send_tick(1'($urandom_range(0, 7) == 0), 1'($urandom_range(0, 1)));
  endtask

  initial begin
    int ph;
    int target;
    logic [uer_pkg::US_W-1:0] tmo;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: outputs straight after reset, a measurement at the reset
    // timeout with echo still high and starts while busy, then a zero
    // timeout that gives up as soon as the trigger pulse ends
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b0);
    run_echo(1, 1, 2, 0);
    write_timeout('0);
    send_tick(1'b1, 1'b0);
    repeat (12) send_tick(1'b0, 1'b0);

    // Random phases, one timeout setting each; the last runs without idling
    for (ph = 0; ph < 6; ph++) begin
      case (ph)
        0:       tmo = 20'd1;
        1:       tmo = 20'd13;
        2:       tmo = 20'($urandom_range(14, 70));
        3:       tmo = 20'($urandom_range(71, 1000000));
        4:       tmo = 20'($urandom_range(20, 45));
        default: tmo = 20'd1000000;
      endcase
      write_timeout(tmo);
      if (ph == 5) quiet <= 1'b1;
      target = ticks_sent + 165;
      while (ticks_sent < target) begin
        if ($urandom_range(0, 4) == 0)
          noise_ticks($urandom_range(5, 30));
        else
          run_echo($urandom_range(0, 3), $urandom_range(1, 4),
                   ($urandom_range(0, 11) == 0) ? $urandom_range(100, 400)
                                                : $urandom_range(1, 40),
                   $urandom_range(0, 3));
      end
    end

    // Drain and settle
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("covered %0d ticks, %0d finished measurements (%0d timed out)",
             tick_count, measure_count, timeout_count);
    $display("across %0d timeout settings from zero to one second", settings_written);
    if (error_count == 0 && outstanding == 0) begin
      $display("[ultrasonic_echo_ranger_smoothed] OK");
    end else begin
      $display("[ultrasonic_echo_ranger_smoothed] ERROR");
    end
    $finish;
  end

  // Hard stop for a hung handshake
  initial begin
    #20_000_000;
    $display("[ultrasonic_echo_ranger_smoothed] ERROR");
    $finish;
  end

endmodule
